/* rtl/vfcm_pkg.sv */
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared sizes, codes and controller/datapath interface types of the voxel
// face-culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int WIDTH_X  = 16;
  localparam int HEIGHT_Y = 256;
  localparam int DEPTH_Z  = 16;

  localparam int ROW_X = WIDTH_X + 2;
  localparam int ROW_Z = DEPTH_Z + 2;

  localparam int VOX_DEPTH  = ROW_X * ROW_Z * HEIGHT_Y;
  localparam int HMAP_DEPTH = ROW_X * ROW_Z;
  localparam int VADDR_W    = $clog2(VOX_DEPTH);
  localparam int HADDR_W    = $clog2(HMAP_DEPTH);
  localparam int XO_W       = $clog2(ROW_X);
  localparam int ZO_W       = $clog2(ROW_Z);

  localparam int POS_W    = 6;
  localparam int Y_W      = 8;
  localparam int CODE_W   = 4;
  localparam int HGT_W    = 9;
  localparam int FACE_W   = 4;
  localparam int CNT_W    = 22;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_DIRS = 6;
  localparam int DIR_W    = 3;

  localparam logic [DIR_W-1:0] DIR_TOP    = 3'd0;
  localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd1;
  localparam logic [DIR_W-1:0] DIR_NORTH  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_SOUTH  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_EAST   = 3'd4;
  localparam logic [DIR_W-1:0] DIR_WEST   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_AIR_CODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAVE_TILE  = 2'd2;

  typedef enum logic [1:0] {
    ACT_WRITE_VOXEL  = 2'd0,
    ACT_WRITE_HEIGHT = 2'd1,
    ACT_QUERY        = 2'd2,
    ACT_NEW_MESH     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_SOLID = 2'd0,
    KIND_CAVE  = 2'd1,
    KIND_WATER = 2'd2
  } kind_t;

  typedef struct packed {
    logic             capture;
    logic             vox_write;
    logic             height_write;
    logic             clear_counts;
    logic             rd_en;
    logic             rd_center;
    logic [DIR_W-1:0] rd_dir;
    logic             emit;
  } vfcm_cmd_t;

  typedef struct packed {
    action_t action;
    logic    query_ok;
    logic    mask_empty;
    logic    out_free;
  } vfcm_status_t;

endpackage

/* rtl/vfcm_ctrl.sv */
// ----------------------------------------------------------------------------
// vfcm_ctrl
// Sequencer of the mesher: takes one item at a time, runs the store writes,
// the counter clear, the seven reads of a query and the emission of its faces.
// ----------------------------------------------------------------------------
module vfcm_ctrl
  import vfcm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  vfcm_status_t status,
  output vfcm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CENTER,
    S_NEIGH,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [DIR_W-1:0] dir_cnt;
  logic [DIR_W-1:0] dir_cnt_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    dir_cnt_next = dir_cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        unique case (status.action)
          ACT_WRITE_VOXEL:  cmd.vox_write    = 1'b1;
          ACT_WRITE_HEIGHT: cmd.height_write = 1'b1;
          ACT_NEW_MESH:     cmd.clear_counts = 1'b1;
          ACT_QUERY: begin
            if (status.query_ok) begin
              state_next = S_CENTER;
            end
          end
        endcase
      end
      S_CENTER: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_center = 1'b1;
        dir_cnt_next  = DIR_TOP;
        state_next    = S_NEIGH;
      end
      S_NEIGH: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_dir   = dir_cnt;
        dir_cnt_next = dir_cnt + 3'd1;
        if (dir_cnt == DIR_WEST) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.mask_empty) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      dir_cnt <= DIR_TOP;
    end else begin
      state   <= state_next;
      dir_cnt <= dir_cnt_next;
    end
  end

endmodule

/* rtl/vfcm_datapath.sv */
// ----------------------------------------------------------------------------
// vfcm_datapath
// Item register, voxel and height stores, face tests, vertex counters and
// the output register of the mesher.
// ----------------------------------------------------------------------------
module vfcm_datapath
  import vfcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  vfcm_cmd_t               cmd,
  output vfcm_status_t            status,
  input  logic [1:0]              action,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic [Y_W-1:0]          pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [CODE_W-1:0]       block_code,
  input  logic [HGT_W-1:0]        column_height,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CODE_W-1:0]       cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              mesh_kind,
  output logic [FACE_W-1:0]       face_x,
  output logic [Y_W-1:0]          face_y,
  output logic [FACE_W-1:0]       face_z,
  output logic [DIR_W-1:0]        face_dir,
  output logic [CODE_W-1:0]       tile_index,
  output logic [CNT_W-1:0]        first_vertex,
  output logic                    last_face
);

  localparam logic signed [POS_W-1:0] POS_HALO_LO = -6'sd1;
  localparam logic signed [POS_W-1:0] POS_ZERO    = 6'sd0;
  localparam logic signed [POS_W-1:0] X_HALO_HI   = POS_W'(WIDTH_X);
  localparam logic signed [POS_W-1:0] Z_HALO_HI   = POS_W'(DEPTH_Z);
  localparam logic [Y_W+1:0]          Y_LIMIT     = (Y_W + 2)'(HEIGHT_Y);
  localparam logic [Y_W:0]            Y_TOP       = (Y_W + 1)'(HEIGHT_Y - 1);
  localparam logic [CNT_W-1:0]        VTX_STEP    = 22'd4;

  logic [CODE_W-1:0] air_code;
  logic [CODE_W-1:0] water_code;
  logic [CODE_W-1:0] cave_tile;

  action_t                 act_q;
  logic signed [POS_W-1:0] x_q;
  logic [Y_W-1:0]          y_q;
  logic signed [POS_W-1:0] z_q;
  logic [CODE_W-1:0]       code_q;
  logic [HGT_W-1:0]        height_q;

  logic [POS_W-1:0]   xp1;
  logic [POS_W-1:0]   zp1;
  logic [XO_W-1:0]    nxo;
  logic [ZO_W-1:0]    nzo;
  logic [Y_W-1:0]     ny;
  logic               noob;
  logic [HADDR_W-1:0] haddr;
  logic [VADDR_W-1:0] vaddr;
  logic               halo_ok;
  logic               wr_ok;

  logic [CODE_W-1:0] vox_mem [VOX_DEPTH];
  logic [HGT_W-1:0]  hgt_mem [HMAP_DEPTH];
  logic [CODE_W-1:0] vox_rd;
  logic [HGT_W-1:0]  hgt_rd;

  logic             rd_v_q;
  logic             rd_center_q;
  logic [DIR_W-1:0] rd_dir_q;
  logic             rd_oob_q;
  logic [Y_W-1:0]   rd_y_q;

  logic              vis_q;
  kind_t             kind_q;
  logic [CODE_W-1:0] tile_q;
  logic [NUM_DIRS-1:0] mask;

  logic rd_air;
  logic rd_below;
  logic nb_air;
  logic nb_water;
  logic nb_cave;
  logic show;

  logic [NUM_DIRS-1:0] emit_onehot;
  logic [DIR_W-1:0]    emit_dir;
  logic                emit_last;

  logic [CNT_W-1:0] solid_cnt;
  logic [CNT_W-1:0] cave_cnt;
  logic [CNT_W-1:0] water_cnt;
  logic [CNT_W-1:0] kind_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      air_code   <= 4'd0;
      water_code <= 4'd1;
      cave_tile  <= 4'd8;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_AIR_CODE:   air_code   <= cfg_data;
        CFG_WATER_CODE: water_code <= cfg_data;
        CFG_CAVE_TILE:  cave_tile  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q    <= action_t'(action);
      x_q      <= pos_x;
      y_q      <= pos_y;
      z_q      <= pos_z;
      code_q   <= block_code;
      height_q <= column_height;
    end
  end

  assign halo_ok = (x_q >= POS_HALO_LO) && (x_q <= X_HALO_HI)
                && (z_q >= POS_HALO_LO) && (z_q <= Z_HALO_HI);
  assign wr_ok   = halo_ok && ({2'b00, y_q} < Y_LIMIT);

  assign status.action     = act_q;
  assign status.query_ok   = (x_q >= POS_ZERO) && (x_q < X_HALO_HI)
                          && (z_q >= POS_ZERO) && (z_q < Z_HALO_HI)
                          && ({2'b00, y_q} < Y_LIMIT);
  assign status.mask_empty = (mask == '0);
  assign status.out_free   = !out_valid || !out_stall;

  assign xp1 = x_q + 6'd1;
  assign zp1 = z_q + 6'd1;

  always_comb begin
    nxo  = xp1[XO_W-1:0];
    nzo  = zp1[ZO_W-1:0];
    ny   = y_q;
    noob = 1'b0;
    if (cmd.rd_en && !cmd.rd_center) begin
      unique case (cmd.rd_dir)
        DIR_TOP: begin
          ny   = y_q + 8'd1;
          noob = ({1'b0, y_q} == Y_TOP);
        end
        DIR_BOTTOM: begin
          ny   = y_q - 8'd1;
          noob = (y_q == '0);
        end
        DIR_NORTH: nzo = zp1[ZO_W-1:0] - ZO_W'(1);
        DIR_SOUTH: nzo = zp1[ZO_W-1:0] + ZO_W'(1);
        DIR_EAST:  nxo = xp1[XO_W-1:0] + XO_W'(1);
        DIR_WEST:  nxo = xp1[XO_W-1:0] - XO_W'(1);
        default: begin
        end
      endcase
    end
  end

  assign haddr = HADDR_W'(HADDR_W'(nzo) * HADDR_W'(ROW_X) + HADDR_W'(nxo));
  assign vaddr = VADDR_W'(VADDR_W'(ny) * VADDR_W'(HMAP_DEPTH) + VADDR_W'(haddr));

  always_ff @(posedge clk) begin
    if (cmd.vox_write && wr_ok) begin
      vox_mem[vaddr] <= code_q;
    end
    if (cmd.rd_en) begin
      vox_rd <= vox_mem[vaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.height_write && halo_ok) begin
      hgt_mem[haddr] <= height_q;
    end
    if (cmd.rd_en) begin
      hgt_rd <= hgt_mem[haddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd.rd_en;
    end
    rd_center_q <= cmd.rd_center;
    rd_dir_q    <= cmd.rd_dir;
    rd_oob_q    <= noob;
    rd_y_q      <= ny;
  end

  assign rd_air   = (vox_rd == air_code);
  assign rd_below = ({1'b0, rd_y_q} < hgt_rd);
  assign nb_air   = rd_oob_q || rd_air;
  assign nb_water = !rd_oob_q && (vox_rd == water_code);
  assign nb_cave  = !rd_oob_q && rd_air && rd_below;

  always_comb begin
    show = 1'b0;
    if (vis_q) begin
      unique case (kind_q)
        KIND_SOLID: show = nb_air || nb_water;
        KIND_WATER: show = nb_air;
        KIND_CAVE:  show = !nb_cave;
        default:    show = 1'b0;
      endcase
    end
  end

  always_comb begin
    emit_onehot = '0;
    emit_dir    = DIR_TOP;
    for (int i = NUM_DIRS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        emit_onehot    = '0;
        emit_onehot[i] = 1'b1;
        emit_dir       = DIR_W'(i);
      end
    end
    emit_last = ((mask & ~emit_onehot) == '0);
  end

  always_ff @(posedge clk) begin
    if (rd_v_q && rd_center_q) begin
      if (rd_air) begin
        vis_q  <= rd_below;
        kind_q <= KIND_CAVE;
        tile_q <= cave_tile;
      end else if (vox_rd == water_code) begin
        vis_q  <= 1'b1;
        kind_q <= KIND_WATER;
        tile_q <= water_code;
      end else begin
        vis_q  <= 1'b1;
        kind_q <= KIND_SOLID;
        tile_q <= vox_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (rd_v_q && !rd_center_q) begin
      mask[rd_dir_q] <= show;
    end else if (cmd.emit) begin
      mask <= mask & ~emit_onehot;
    end
  end

  always_comb begin
    unique case (kind_q)
      KIND_SOLID: kind_cnt = solid_cnt;
      KIND_CAVE:  kind_cnt = cave_cnt;
      KIND_WATER: kind_cnt = water_cnt;
      default:    kind_cnt = solid_cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_counts) begin
      solid_cnt <= '0;
      cave_cnt  <= '0;
      water_cnt <= '0;
    end else if (cmd.emit) begin
      unique case (kind_q)
        KIND_SOLID: solid_cnt <= solid_cnt + VTX_STEP;
        KIND_CAVE:  cave_cnt  <= cave_cnt + VTX_STEP;
        KIND_WATER: water_cnt <= water_cnt + VTX_STEP;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      mesh_kind    <= kind_q;
      face_x       <= x_q[FACE_W-1:0];
      face_y       <= y_q;
      face_z       <= z_q[FACE_W-1:0];
      face_dir     <= emit_dir;
      tile_index   <= tile_q;
      first_vertex <= kind_cnt;
      last_face    <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_emit_has_face: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (mask != '0))
    else $error("Emission requested with no visible face left.");

  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("Emitted face did not reach the output register.");

  a_last_empties_mask: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && emit_last) |=> (mask == '0))
    else $error("Faces remain after the last face of a query.");

  a_clear_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_counts |=> (solid_cnt == '0 && cave_cnt == '0 && water_cnt == '0))
    else $error("Vertex counters not cleared by a new-mesh item.");
`endif

endmodule

/* rtl/voxel_face_culling_mesher.sv */
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher
// Holds a voxel chunk with its halo and column heights, and emits one quad
// per visible face of each queried voxel.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A voxel write, a height write or a
// new-mesh item is captured and then executed; the input is free again on
// the cycle after it is executed. A query reads the voxel store, which has
// a single port, seven times in turn, once for the voxel and once per
// neighbor, and each face then leaves through the output register one per
// cycle while the output is not stalled. A query outside the chunk interior
// emits nothing. Both stores come out of reset undefined and need no
// clearing pass; every cell that is queried, with its neighbors and their
// column heights, must be loaded first.
module voxel_face_culling_mesher
  import vfcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic [Y_W-1:0]          pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [CODE_W-1:0]       block_code,
  input  logic [HGT_W-1:0]        column_height,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CODE_W-1:0]       cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              mesh_kind,
  output logic [FACE_W-1:0]       face_x,
  output logic [Y_W-1:0]          face_y,
  output logic [FACE_W-1:0]       face_z,
  output logic [DIR_W-1:0]        face_dir,
  output logic [CODE_W-1:0]       tile_index,
  output logic [CNT_W-1:0]        first_vertex,
  output logic                    last_face
);

  vfcm_cmd_t    cmd;
  vfcm_status_t status;

  vfcm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  vfcm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .action        (action),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .pos_z         (pos_z),
    .block_code    (block_code),
    .column_height (column_height),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mesh_kind     (mesh_kind),
    .face_x        (face_x),
    .face_y        (face_y),
    .face_z        (face_z),
    .face_dir      (face_dir),
    .tile_index    (tile_index),
    .first_vertex  (first_vertex),
    .last_face     (last_face)
  );

endmodule
